>>> rtl/jsd_pkg.sv
// Shared constants, codes and types of the joystick scaling and direction block.
package jsd_pkg;

  // Field widths
  localparam int unsigned SampleW  = 8;
  localparam int unsigned PctW     = 8;
  localparam int unsigned MagW     = 7;
  localparam int unsigned ThrW     = 7;
  localparam int unsigned HeadW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Scaling constants
  localparam int unsigned FullScale = 100;
  localparam int unsigned SampleMax = 255;

  // Quotient never exceeds 100, so seven quotient bits are enough
  localparam int unsigned QuotW = 7;
  // Numerator is at most 255 * 100
  localparam int unsigned NumW  = 15;

  // Lane: entry stage, one stage per quotient bit, result stage
  localparam int unsigned LaneStages = QuotW + 2;
  // Whole pipeline: lane stages plus the heading/output stage
  localparam int unsigned NumStages  = LaneStages + 1;

  // Reset values of the configuration registers
  localparam logic [SampleW-1:0] CenterReset    = 8'd128;
  localparam logic [ThrW-1:0]    ThresholdReset = 7'd50;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_X_CENTER  = 2'd0,
    REG_Y_CENTER  = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_e;

  // Heading codes
  typedef enum logic [HeadW-1:0] {
    HEAD_NEUTRAL = 3'd0,
    HEAD_RIGHT   = 3'd1,
    HEAD_LEFT    = 3'd2,
    HEAD_UP      = 3'd3,
    HEAD_DOWN    = 3'd4
  } heading_e;

  // Scaled result of one axis
  typedef struct packed {
    logic [PctW-1:0] pct;  // signed percent, two's complement
    logic [MagW-1:0] mag;  // magnitude of pct
  } axis_t;

endpackage

>>> rtl/jsd_axis_lane.sv
// Pipelined scaling of one joystick axis: restoring division, one quotient bit a stage.
module jsd_axis_lane (
  input  logic                                clk_i,
  input  logic [jsd_pkg::LaneStages-1:0]      en_i,
  input  logic [jsd_pkg::SampleW-1:0]         sample_i,
  input  logic [jsd_pkg::SampleW-1:0]         center_i,
  output jsd_pkg::axis_t                      axis_o
);

  localparam int unsigned QW = jsd_pkg::QuotW;
  localparam int unsigned NW = jsd_pkg::NumW;
  localparam int unsigned SW = jsd_pkg::SampleW;

  // Stage 0 is the entry register, stages 1..QW hold partial quotients
  logic [NW-1:0] rem_q  [0:QW];
  logic [QW-1:0] quo_q  [0:QW];
  logic [SW-1:0] div_q  [0:QW];
  logic          up_q   [0:QW];
  logic          zero_q [0:QW];

  logic          upper;
  logic [SW-1:0] diff;
  logic [NW-1:0] num_d;
  logic [SW-1:0] div_d;

  // Pick the side of the midpoint and form numerator and divisor
  always_comb begin
    upper = sample_i > center_i;
    diff  = upper ? (sample_i - center_i) : sample_i;
    num_d = NW'(diff) * NW'(jsd_pkg::FullScale);
    div_d = upper ? (SW'(jsd_pkg::SampleMax) - center_i) : center_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= num_d;
      quo_q[0]  <= '0;
      div_q[0]  <= div_d;
      up_q[0]   <= upper;
      zero_q[0] <= !upper && (center_i == '0);
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int unsigned Sh = QW - k;
    logic [NW-1:0] dsh;
    logic          ge;

    always_comb begin
      dsh = NW'(div_q[k-1]) << Sh;
      ge  = rem_q[k-1] >= dsh;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= ge ? (rem_q[k-1] - dsh) : rem_q[k-1];
        quo_q[k]  <= quo_q[k-1] | (QW'(ge) << Sh);
        div_q[k]  <= div_q[k-1];
        up_q[k]   <= up_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  logic [jsd_pkg::PctW-1:0] pct_d;
  logic [jsd_pkg::MagW-1:0] mag_d;
  logic [jsd_pkg::PctW-1:0] quo_ext;

  // Map the quotient to a signed percent and its magnitude
  always_comb begin
    quo_ext = jsd_pkg::PctW'(quo_q[QW]);
    if (zero_q[QW]) begin
      pct_d = -jsd_pkg::PctW'(jsd_pkg::FullScale);
      mag_d = jsd_pkg::MagW'(jsd_pkg::FullScale);
    end else if (up_q[QW]) begin
      pct_d = quo_ext;
      mag_d = quo_q[QW];
    end else begin
      pct_d = quo_ext - jsd_pkg::PctW'(jsd_pkg::FullScale);
      mag_d = jsd_pkg::MagW'(jsd_pkg::FullScale) - quo_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[QW+1]) begin
      axis_o.pct <= pct_d;
      axis_o.mag <= mag_d;
    end
  end

endmodule

>>> rtl/joystick_scale_and_direction.sv
// Top level: joystick axis scaling to percent, heading decision and slider pass-through.
//
// Usage
//   Slave stream s_axis_*: one sample set per transfer (x, y, left, right bytes).
//   Master stream m_axis_*: one result per sample set, in order (x and y
//   percent in -100..100, left and right slider bytes, heading code).
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 x midpoint, 1 y midpoint, 2 heading threshold); other indexes are
//   ignored. Write only while no transfer is in flight.
// Timing
//   From an input transfer to its output transfer a sample set passes an
//   entry stage, seven restoring division stages (one quotient bit each), a
//   percent stage and the heading/output register. Throughput is one sample
//   set per cycle while m_axis_tready does not hold the pipeline back;
//   both axes have their own divider.
// Reset
//   Clears all stage valid bits and loads midpoints of 128 and threshold 50.
// Stall
//   Each stage holds while its successor is full and stalled; empty stages
//   keep filling, so s_axis_tready drops only once every stage holds an item.
module joystick_scale_and_direction (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [jsd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [jsd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // x_sample, y_sample, left_sample,
                                                         // right_sample
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata   // x_percent, y_percent, left_level,
                                                         // right_level, heading, zero pad
);

  localparam int unsigned NS = jsd_pkg::NumStages;
  localparam int unsigned LS = jsd_pkg::LaneStages;

  // Configuration registers
  logic [jsd_pkg::SampleW-1:0] x_center_q, y_center_q;
  logic [jsd_pkg::ThrW-1:0]    thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_center_q <= jsd_pkg::CenterReset;
      y_center_q <= jsd_pkg::CenterReset;
      thr_q      <= jsd_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jsd_pkg::REG_X_CENTER:  x_center_q <= cfg_wdata_i;
        jsd_pkg::REG_Y_CENTER:  y_center_q <= cfg_wdata_i;
        jsd_pkg::REG_THRESHOLD: thr_q      <= cfg_wdata_i[jsd_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NS-1:0] valid_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign s_axis_tready = adv[0];

  // Slider bytes travel beside the axis lanes
  logic [15:0] slide_q [0:NS-1];

  always_ff @(posedge clk_i) begin
    if (adv[0]) slide_q[0] <= s_axis_tdata[31:16];
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) slide_q[k] <= slide_q[k-1];
    end
  end

  // Axis scaling lanes
  jsd_pkg::axis_t x_axis, y_axis;

  jsd_axis_lane u_x_lane (
    .clk_i    (clk_i),
    .en_i     (adv[LS-1:0]),
    .sample_i (s_axis_tdata[7:0]),
    .center_i (x_center_q),
    .axis_o   (x_axis)
  );

  jsd_axis_lane u_y_lane (
    .clk_i    (clk_i),
    .en_i     (adv[LS-1:0]),
    .sample_i (s_axis_tdata[15:8]),
    .center_i (y_center_q),
    .axis_o   (y_axis)
  );

  // Heading from the larger magnitude; a tie goes to the vertical axis
  jsd_pkg::heading_e head_d, head_q;

  always_comb begin
    if (x_axis.mag > y_axis.mag) begin
      if (x_axis.mag > thr_q) begin
        head_d = x_axis.pct[jsd_pkg::PctW-1] ? jsd_pkg::HEAD_LEFT : jsd_pkg::HEAD_RIGHT;
      end else begin
        head_d = jsd_pkg::HEAD_NEUTRAL;
      end
    end else begin
      if (y_axis.mag > thr_q) begin
        head_d = y_axis.pct[jsd_pkg::PctW-1] ? jsd_pkg::HEAD_DOWN : jsd_pkg::HEAD_UP;
      end else begin
        head_d = jsd_pkg::HEAD_NEUTRAL;
      end
    end
  end

  // Output register
  logic [jsd_pkg::PctW-1:0] x_pct_q, y_pct_q;

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      x_pct_q <= x_axis.pct;
      y_pct_q <= y_axis.pct;
      head_q  <= head_d;
    end
  end

  assign m_axis_tvalid = valid_q[NS-1];
  assign m_axis_tdata  = {5'd0, head_q, slide_q[NS-1], y_pct_q, x_pct_q};

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_q))
    else $error("input stalled while a stage is empty");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(x_pct_q) >= -100 && $signed(x_pct_q) <= 100))
    else $error("x percent out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(y_pct_q) >= -100 && $signed(y_pct_q) <= 100))
    else $error("y percent out of range");

  a_right_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && head_q == jsd_pkg::HEAD_RIGHT) |-> ($signed(x_pct_q) > 0))
    else $error("right heading with non-positive x");

endmodule
